>>> rtl/core/bllsr_pkg.sv
// Shared types and codes for the bounded linked list search/remove core.
package bllsr_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned KindW  = 2;
  localparam int unsigned StatW  = 2;

  // Operation codes
  localparam logic [KindW-1:0] KIND_INSERT = 2'd0;
  localparam logic [KindW-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KindW-1:0] KIND_REMOVE = 2'd2;

  // Result status codes
  localparam logic [StatW-1:0] ST_OK        = 2'd0;
  localparam logic [StatW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatW-1:0] ST_FULL      = 2'd2;

  // Source of the node store read address
  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,
    RD_FREE = 2'd1,
    RD_LINK = 2'd2
  } rd_src_e;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_INSERT  = 5'b00010,
    S_WALK    = 5'b00100,
    S_RELEASE = 5'b01000,
    S_FINISH  = 5'b10000
  } state_e;

  typedef struct packed {
    logic             start;
    logic             rd_en;
    rd_src_e          rd_src;
    logic             step;
    logic             insert;
    logic             unlink;
    logic             release_node;
    logic             set_res;
    logic [StatW-1:0] res;
    logic             load_out;
  } bllsr_cmd_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             full;
    logic             head_null;
    logic             match;
    logic             next_null;
  } bllsr_stat_t;

endpackage

>>> rtl/core/bllsr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module bllsr_ram #(
  parameter  int unsigned Width = 32,
  parameter  int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bllsr_dp.sv
// Datapath: node store, list head, free list and result registers.
module bllsr_dp #(
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bllsr_pkg::bllsr_cmd_t               cmd_i,
  input  logic [bllsr_pkg::KindW-1:0]         kind_i,
  input  logic signed [bllsr_pkg::ValueW-1:0] value_i,
  output bllsr_pkg::bllsr_stat_t              stat_o,
  output logic [bllsr_pkg::StatW-1:0]         status_o,
  output logic [CntW-1:0]                     count_o
);
  import bllsr_pkg::*;

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CntW-1:0] NullIdx = CntW'(DEPTH);

  // Control state
  logic [CntW-1:0] head_q, head_d;
  logic [CntW-1:0] free_q, free_d;   // head of the free slot chain
  logic [CntW-1:0] fill_q, fill_d;   // slots below this have been used once
  logic [CntW-1:0] count_q, count_d;

  // Per-item working registers
  logic [KindW-1:0]  kind_q;
  logic [ValueW-1:0] value_q;
  logic [CntW-1:0]   cur_q;
  logic [CntW-1:0]   prev_q;
  logic [StatW-1:0]  res_q;
  logic [StatW-1:0]  out_status_q;
  logic [CntW-1:0]   out_count_q;

  logic [CntW-1:0]   slot;
  logic [CntW-1:0]   rd_idx;
  logic              rd_en;
  logic [ValueW-1:0] val_rd;
  logic [CntW-1:0]   lnk_rd;
  logic              lnk_we;
  logic [CntW-1:0]   lnk_waddr;
  logic [CntW-1:0]   lnk_wdata;

  assign slot = (free_q != NullIdx) ? free_q : fill_q;

  always_comb begin
    case (cmd_i.rd_src)
      RD_HEAD: rd_idx = head_q;
      RD_FREE: rd_idx = free_q;
      RD_LINK: rd_idx = lnk_rd;
      default: rd_idx = head_q;
    endcase
  end

  assign rd_en = cmd_i.rd_en && (rd_idx != NullIdx);

  always_comb begin
    lnk_we    = 1'b0;
    lnk_waddr = slot;
    lnk_wdata = head_q;
    if (cmd_i.insert) begin
      lnk_we = 1'b1;
    end else if (cmd_i.unlink && (prev_q != NullIdx)) begin
      lnk_we    = 1'b1;
      lnk_waddr = prev_q;
      lnk_wdata = lnk_rd;
    end else if (cmd_i.release_node) begin
      // freed node joins the free chain
      lnk_we    = 1'b1;
      lnk_waddr = cur_q;
      lnk_wdata = free_q;
    end
  end

  bllsr_ram #(
    .Width (ValueW),
    .Depth (DEPTH)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.insert),
    .waddr_i (slot[AddrW-1:0]),
    .wdata_i (value_q),
    .re_i    (rd_en),
    .raddr_i (rd_idx[AddrW-1:0]),
    .rdata_o (val_rd)
  );

  bllsr_ram #(
    .Width (CntW),
    .Depth (DEPTH)
  ) u_lnk_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr[AddrW-1:0]),
    .wdata_i (lnk_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_idx[AddrW-1:0]),
    .rdata_o (lnk_rd)
  );

  always_comb begin
    head_d  = head_q;
    free_d  = free_q;
    fill_d  = fill_q;
    count_d = count_q;
    if (cmd_i.insert) begin
      head_d  = slot;
      count_d = count_q + CntW'(1);
      if (free_q != NullIdx) begin
        free_d = lnk_rd;   // link of the popped free slot, read on accept
      end else begin
        fill_d = fill_q + CntW'(1);
      end
    end
    if (cmd_i.unlink && (prev_q == NullIdx)) begin
      head_d = lnk_rd;
    end
    if (cmd_i.release_node) begin
      free_d  = cur_q;
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= NullIdx;
      free_q  <= NullIdx;
      fill_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      free_q  <= free_d;
      fill_q  <= fill_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      kind_q  <= kind_i;
      value_q <= value_i;
      cur_q   <= head_q;
      prev_q  <= NullIdx;
    end else if (cmd_i.step) begin
      prev_q <= cur_q;
      cur_q  <= lnk_rd;
    end
    if (cmd_i.set_res) begin
      res_q <= cmd_i.res;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_q;
      out_count_q  <= count_q;
    end
  end

  assign stat_o.kind      = kind_q;
  assign stat_o.full      = (count_q == CntW'(DEPTH));
  assign stat_o.head_null = (head_q == NullIdx);
  assign stat_o.match     = (val_rd == value_q);
  assign stat_o.next_null = (lnk_rd == NullIdx);

  assign status_o = out_status_q;
  assign count_o  = out_count_q;

endmodule

>>> rtl/core/bllsr_ctrl.sv
// Controller: sequences insert, walk and unlink, and owns both handshakes.
module bllsr_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [bllsr_pkg::KindW-1:0] kind_i,
  output logic                        in_stall_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  bllsr_pkg::bllsr_stat_t      stat_i,
  output bllsr_pkg::bllsr_cmd_t       cmd_o
);
  import bllsr_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.rd_src = RD_HEAD;
    cmd_o.res    = ST_OK;
    in_stall_o  = 1'b1;

    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          case (kind_i)
            KIND_INSERT: begin
              if (stat_i.full) begin
                cmd_o.set_res = 1'b1;
                cmd_o.res     = ST_FULL;
                state_d       = S_FINISH;
              end else begin
                // fetch the free chain link; unused when the chain is empty
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_src = RD_FREE;
                state_d      = S_INSERT;
              end
            end
            KIND_SEARCH, KIND_REMOVE: begin
              if (stat_i.head_null) begin
                cmd_o.set_res = 1'b1;
                cmd_o.res     = ST_NOT_FOUND;
                state_d       = S_FINISH;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_src = RD_HEAD;
                state_d      = S_WALK;
              end
            end
            default: begin
              cmd_o.set_res = 1'b1;
              cmd_o.res     = ST_OK;
              state_d       = S_FINISH;
            end
          endcase
        end
      end
      S_INSERT: begin
        cmd_o.insert  = 1'b1;
        cmd_o.set_res = 1'b1;
        cmd_o.res     = ST_OK;
        state_d       = S_FINISH;
      end
      S_WALK: begin
        if (stat_i.match) begin
          if (stat_i.kind == KIND_REMOVE) begin
            cmd_o.unlink = 1'b1;
            state_d      = S_RELEASE;
          end else begin
            cmd_o.set_res = 1'b1;
            cmd_o.res     = ST_OK;
            state_d       = S_FINISH;
          end
        end else if (stat_i.next_null) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res     = ST_NOT_FOUND;
          state_d       = S_FINISH;
        end else begin
          // next address comes straight from the link just read
          cmd_o.step   = 1'b1;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = RD_LINK;
        end
      end
      S_RELEASE: begin
        cmd_o.release_node = 1'b1;
        cmd_o.set_res      = 1'b1;
        cmd_o.res          = ST_OK;
        state_d            = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/bounded_linked_list_search_remove_core.sv
// Bounded linked list core: insert at head, search, and remove first match.
//
// Input channel (in_valid_i / in_stall_o) carries one word: kind_i selects
// insert (0), search (1) or remove (2); kind 3 is a no-op. value_i is the
// 32-bit value, compared as a raw bit pattern. Each word yields exactly one
// output word (out_valid_o / out_stall_i): status_o (0 ok/found, 1 not
// found, 2 full) and count_o, the number of values held afterwards.
// From accept to result: a full store, an empty list or a no-op goes
// straight to the finish state; an insert passes the insert state first; a
// search walks its nodes first, and a remove that matches adds a release step.
// The walk follows the link memory one node per cycle, each read address
// taken from the link read the cycle before. One word is in flight at a
// time; the next word is accepted the cycle after the previous result is
// loaded, even while that result still sits in the output register.
// A stalled result holds; the block then finishes its current word and
// waits. Reset empties the list at once (no clearing pass); the node
// memories need no initialization.
module bounded_linked_list_search_remove_core #(
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bllsr_pkg::KindW-1:0]         kind_i,
  input  logic signed [bllsr_pkg::ValueW-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bllsr_pkg::StatW-1:0]         status_o,
  output logic [CntW-1:0]                     count_o
);
  import bllsr_pkg::*;

  bllsr_cmd_t  cmd;
  bllsr_stat_t stat;

  bllsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bllsr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .kind_i   (kind_i),
    .value_i  (value_i),
    .stat_o   (stat),
    .status_o (status_o),
    .count_o  (count_o)
  );

  // A full refusal always reports a full store
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> (count_o == CntW'(DEPTH)))
    else $error("full status with count below depth");

  // An accepted word keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block idle right after accept");

  // Unlinking a node is always followed by releasing it
  a_unlink_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.unlink |=> cmd.release_node)
    else $error("unlinked node not released");

  // Count never exceeds the store size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= CntW'(DEPTH)))
    else $error("count above depth");

endmodule
